// ===== rtl/kfr_pkg.sv =====
package kfr_pkg;

  localparam int KEY_W           = 37;
  localparam int PAY_W           = 64;
  localparam int POS_W           = 5;
  localparam int OCC_W           = 5;
  localparam int FUNC_W          = 2;
  localparam int STAT_W          = 3;
  localparam int DEF_QUEUE_DEPTH = 16;

  // slave tdata: key, payload_in, padded to whole bytes
  localparam int S_DATA_W = ((KEY_W + PAY_W + 7) / 8) * 8;
  // master tdata: payload_out, position, occupancy, padded to whole bytes
  localparam int M_DATA_W = ((PAY_W + POS_W + OCC_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQ = 2'd0,
    FUNC_DEQ = 2'd1,
    FUNC_REM = 2'd2,
    FUNC_POS = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // control broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic commit;
    logic enq;
    logic deq;
    logic rem;
  } cell_ctl_t;

endpackage

// ===== rtl/kfr_cell.sv =====
module kfr_cell
  import kfr_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [KEY_W-1:0] cmp_key,
  input  logic [PAY_W-1:0] new_payload,
  input  logic             valid,
  input  logic             tail,
  input  logic             head,
  input  logic             shift_in,
  input  logic [KEY_W-1:0] nxt_key,
  input  logic [PAY_W-1:0] nxt_payload,
  output logic [KEY_W-1:0] key,
  output logic [PAY_W-1:0] payload,
  output logic             match,
  output logic             shift_out
);

  logic sel;

  // this cell is the one that leaves the queue
  assign sel       = valid & ((ctl.rem & match) | (ctl.deq & head));
  // every cell at or behind the removed one pulls its neighbor's entry
  assign shift_out = shift_in | sel;

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      match <= valid && (key == cmp_key);
    end
    if (ctl.commit) begin
      if (shift_out) begin
        key     <= nxt_key;
        payload <= nxt_payload;
      end else if (ctl.enq && tail) begin
        key     <= cmp_key;
        payload <= new_payload;
      end
    end
  end

endmodule

// ===== rtl/keyed_fifo_with_removal_unit.sv =====
// flow: an accepted word is captured, its key is compared in every cell (S_CMP), and then
// the cell chain and result register are updated (S_EXEC), which waits while an earlier result is stalled
// a new word is taken only after the previous one has finished its compare-then-update pass,
// but while the previous result still waits on m_tready
// reset: rst (synchronous, active high) empties the queue and drops m_tvalid;
// cell contents are not cleared, entries beyond the occupancy are never read
module keyed_fifo_with_removal_unit
  import kfr_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // key, payload_in, zero pad
  input  logic [FUNC_W-1:0]   s_tuser,   // func
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // payload_out, position, occupancy, zero pad
  output logic [STAT_W-1:0]   m_tuser    // status
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state, state_next;

  logic [FUNC_W-1:0] func_q;
  logic [KEY_W-1:0]  key_q;
  logic [PAY_W-1:0]  pay_q;
  logic [CNT_W-1:0]  count;

  logic [PAY_W-1:0]  pay_out;
  logic [POS_W-1:0]  pos_out;
  logic [OCC_W-1:0]  occ_out;
  logic [STAT_W-1:0] stat_out;

  cell_ctl_t        ctl;
  logic [KEY_W-1:0] cell_key   [QUEUE_DEPTH];
  logic [PAY_W-1:0] cell_pay   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH:0]   shift;

  logic             fire, found, empty, full;
  logic             enq_ok, deq_ok, rem_ok;
  logic [CNT_W-1:0] pos_full;
  status_t          status;
  func_t            func;

  assign s_tready = (state == S_IDLE);
  assign fire     = (state == S_EXEC) && (!m_tvalid || m_tready);
  assign func     = func_t'(func_q);

  assign found = |match;
  assign empty = (count == '0);
  assign full  = (count == CNT_W'(QUEUE_DEPTH));

  assign enq_ok = (func == FUNC_ENQ) && !found && !full;
  assign deq_ok = (func == FUNC_DEQ) && !empty;
  assign rem_ok = (func == FUNC_REM) && found;

  assign ctl.cmp_en = (state == S_CMP);
  assign ctl.commit = fire;
  assign ctl.enq    = enq_ok;
  assign ctl.deq    = deq_ok;
  assign ctl.rem    = rem_ok;

  assign shift[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic [KEY_W-1:0] nk;
      logic [PAY_W-1:0] np;
      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign nk = cell_key[gi];
        assign np = cell_pay[gi];
      end else begin : g_mid
        assign nk = cell_key[gi+1];
        assign np = cell_pay[gi+1];
      end
      kfr_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .cmp_key     (key_q),
        .new_payload (pay_q),
        .valid       (CNT_W'(gi) < count),
        .tail        (CNT_W'(gi) == count),
        .head        (gi == 0),
        .shift_in    (shift[gi]),
        .nxt_key     (nk),
        .nxt_payload (np),
        .key         (cell_key[gi]),
        .payload     (cell_pay[gi]),
        .match       (match[gi]),
        .shift_out   (shift[gi+1])
      );
    end
  endgenerate

  // keys are unique among valid cells, so at most one match bit is set
  always_comb begin
    pos_full = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (match[i]) pos_full = pos_full | CNT_W'(i + 1);
    end
  end

  always_comb begin
    status = ST_OK;
    unique case (func)
      FUNC_ENQ: begin
        if (found)     status = ST_DUP;
        else if (full) status = ST_FULL;
      end
      FUNC_DEQ: begin
        if (empty) status = ST_EMPTY;
      end
      FUNC_REM: begin
        if (!found) status = ST_NOTFOUND;
      end
      FUNC_POS: begin
        if (empty)       status = ST_EMPTY;
        else if (!found) status = ST_NOTFOUND;
      end
      default: status = ST_OK;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid) state_next = S_CMP;
      S_CMP:   state_next = S_EXEC;
      S_EXEC:  if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        m_tvalid <= 1'b1;
        if (enq_ok)               count <= count + CNT_W'(1);
        else if (deq_ok || rem_ok) count <= count - CNT_W'(1);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func_q <= s_tuser;
      key_q  <= s_tdata[KEY_W-1:0];
      pay_q  <= s_tdata[KEY_W+PAY_W-1:KEY_W];
    end
    if (fire) begin
      stat_out <= status;
      pay_out  <= deq_ok ? cell_pay[0] : '0;
      pos_out  <= (func == FUNC_POS && !empty) ? POS_W'(pos_full) : '0;
      // occupancy after this operation
      if (enq_ok)                occ_out <= OCC_W'(count + CNT_W'(1));
      else if (deq_ok || rem_ok) occ_out <= OCC_W'(count - CNT_W'(1));
      else                       occ_out <= OCC_W'(count);
    end
  end

  assign m_tuser = stat_out;
  assign m_tdata = {{(M_DATA_W - PAY_W - POS_W - OCC_W){1'b0}}, occ_out, pos_out, pay_out};

endmodule

// ===== rtl/kfr_checker.sv =====
module kfr_checker
  import kfr_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [S_DATA_W-1:0] s_tdata,
  input logic [FUNC_W-1:0]   s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic [STAT_W-1:0]   m_tuser
);

  localparam int POS_LO = PAY_W;
  localparam int OCC_LO = PAY_W + POS_W;

  // a result word that is stalled keeps its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  // an empty report always comes with zero occupancy
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_EMPTY) |-> (m_tdata[OCC_LO+OCC_W-1:OCC_LO] == '0))
    else $error("empty status with nonzero occupancy");

  // a position or a dequeued payload is only reported on success
  a_pos_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[POS_LO+POS_W-1:POS_LO] != '0) |-> (m_tuser == ST_OK))
    else $error("position reported with failing status");

  a_pay_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[PAY_W-1:0] != '0) |-> (m_tuser == ST_OK))
    else $error("payload reported with failing status");

  // the result of an accepted word cannot appear in the very next cycle
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result word appeared too early");

endmodule

bind keyed_fifo_with_removal_unit kfr_checker u_kfr_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import kfr_pkg::*;

  localparam int DEPTH      = DEF_QUEUE_DEPTH;
  localparam int RAND_WORDS = 1074;
  localparam int CALM_TAIL  = 150;
  localparam int LONG_HOLD  = 300;
  localparam int POOL_N     = 24;

  typedef struct packed {
    status_t              status;
    logic [PAY_W-1:0]     payload;
    logic [POS_W-1:0]     position;
    logic [OCC_W-1:0]     occupancy;
  } queue_result_t;

  typedef struct packed {
    func_t                f;
    logic [KEY_W-1:0]     key;
    logic [PAY_W-1:0]     pay;
    logic                 typed;
    queue_result_t        want;
  } op_row_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
  } held_entry_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;   // key, payload_in, zero pad
  logic [FUNC_W-1:0]   s_tuser = '0;   // func
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;        // payload_out, position, occupancy, zero pad
  logic [STAT_W-1:0]   m_tuser;        // status

  keyed_fifo_with_removal_unit #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mirror of the queue contents, head at index 0
  held_entry_t   held[$];
  queue_result_t replies_due[$];
  queue_result_t want;

  int          errors = 0;
  int          idle_odds = 0;   // 0: no idling, n: one word in n starts a gap
  int          func_sent[4];
  int          status_seen[8];
  int          peak_depth = 0;
  int          words_checked = 0;
  int unsigned rx_stall_left = 0;
  int unsigned rx_hold_left = 0;
  bit          rx_hold_req = 1'b0;

  function automatic queue_result_t apply_queue_op(func_t f, logic [KEY_W-1:0] k,
                                                   logic [PAY_W-1:0] p);
    queue_result_t r;
    held_entry_t   e;
    int            hit;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    foreach (held[i]) if (hit < 0 && held[i].key == k) hit = i;
    case (f)
      FUNC_ENQ: begin
        if (hit >= 0) r.status = ST_DUP;
        else if (held.size() >= DEPTH) r.status = ST_FULL;
        else begin
          e.key = k;
          e.pay = p;
          held.push_back(e);
        end
      end
      FUNC_DEQ: begin
        if (held.size() == 0) r.status = ST_EMPTY;
        else begin
          e = held.pop_front();
          r.payload = e.pay;
        end
      end
      FUNC_REM: begin
        if (hit < 0) r.status = ST_NOTFOUND;
        else held.delete(hit);
      end
      default: begin
        if (held.size() == 0) r.status = ST_EMPTY;
        else if (hit < 0) r.status = ST_NOTFOUND;
        else r.position = POS_W'(hit + 1);
      end
    endcase
    r.occupancy = OCC_W'(held.size());
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    errors++;
    if (errors <= 40) $display("mismatch at %0t, result %0d: %s", $time, words_checked, what);
  endtask

  // one word on the slave side, with an optional random gap ahead of it
  task automatic offer_word(func_t f, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p,
                            logic typed, queue_result_t typed_res);
    queue_result_t r;
    int            gap;
    gap = 0;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) gap = $urandom_range(1, 15);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tuser  <= FUNC_W'($urandom());
      s_tdata  <= S_DATA_W'({$urandom(), $urandom(), $urandom(), $urandom()});
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {{(S_DATA_W - KEY_W - PAY_W){1'b0}}, p, k};
    do @(posedge clk); while (!s_tready);
    r = apply_queue_op(f, k, p);
    replies_due.push_back(typed ? typed_res : r);
    func_sent[f]++;
    if (held.size() > peak_depth) peak_depth = held.size();
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold_left = LONG_HOLD;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else if (rx_stall_left != 0) begin
      rx_stall_left--;
      m_tready <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      rx_stall_left = $urandom_range(0, 14);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      words_checked++;
      status_seen[m_tuser]++;
      if (replies_due.size() == 0) begin
        flag_mismatch("result word with nothing outstanding");
      end else begin
        want = replies_due.pop_front();
        if (m_tuser !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
        if (m_tdata[PAY_W-1:0] !== want.payload)
          flag_mismatch($sformatf("payload_out %h, want %h", m_tdata[PAY_W-1:0],
                                  want.payload));
        if (m_tdata[PAY_W+POS_W-1:PAY_W] !== want.position)
          flag_mismatch($sformatf("position %0d, want %0d", m_tdata[PAY_W+POS_W-1:PAY_W],
                                  want.position));
        if (m_tdata[PAY_W+POS_W+OCC_W-1:PAY_W+POS_W] !== want.occupancy)
          flag_mismatch($sformatf("occupancy %0d, want %0d",
                                  m_tdata[PAY_W+POS_W+OCC_W-1:PAY_W+POS_W], want.occupancy));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL keyed_fifo_with_removal_unit");
    $finish;
  end

  initial begin
    op_row_t          dir_rows[26];
    logic [KEY_W-1:0] key_pool[POOL_N];
    logic [KEY_W-1:0] k;
    logic [PAY_W-1:0] p;
    func_t            f;
    int               mode;
    int               phase_left;
    int               pick;

    // empty queue, duplicates, extremes of key and payload
    dir_rows[0] = '{FUNC_DEQ, '0, '0, 1'b1, '{ST_EMPTY, '0, 5'd0, 5'd0}};
    dir_rows[1] = '{FUNC_POS, '1, '0, 1'b1, '{ST_EMPTY, '0, 5'd0, 5'd0}};
    dir_rows[2] = '{FUNC_REM, '0, '1, 1'b1, '{ST_NOTFOUND, '0, 5'd0, 5'd0}};
    dir_rows[3] = '{FUNC_ENQ, '0, '0, 1'b1, '{ST_OK, '0, 5'd0, 5'd1}};
    dir_rows[4] = '{FUNC_ENQ, '0, '1, 1'b1, '{ST_DUP, '0, 5'd0, 5'd1}};
    dir_rows[5] = '{FUNC_ENQ, '1, '1, 1'b1, '{ST_OK, '0, 5'd0, 5'd2}};
    // fill up to the full depth
    for (int i = 0; i < 14; i++)
      dir_rows[6+i] = '{FUNC_ENQ, (i == 0) ? 37'd99999999999 : 37'(1000 + i * 7777777),
                        {$urandom(), $urandom()}, 1'b0, '0};
    dir_rows[20] = '{FUNC_ENQ, 37'd12345, '0, 1'b1, '{ST_FULL, '0, 5'd0, 5'd16}};
    // duplicate wins over full
    dir_rows[21] = '{FUNC_ENQ, '0, '1, 1'b1, '{ST_DUP, '0, 5'd0, 5'd16}};
    dir_rows[22] = '{FUNC_POS, '1, '0, 1'b1, '{ST_OK, '0, 5'd2, 5'd16}};
    dir_rows[23] = '{FUNC_REM, '1, '0, 1'b1, '{ST_OK, '0, 5'd0, 5'd15}};
    dir_rows[24] = '{FUNC_POS, 37'd55, '0, 1'b1, '{ST_NOTFOUND, '0, 5'd0, 5'd15}};
    dir_rows[25] = '{FUNC_DEQ, '0, '0, 1'b1, '{ST_OK, '0, 5'd0, 5'd14}};

    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 37'd99999999999;
    for (int i = 3; i < POOL_N; i++) key_pool[i] = KEY_W'({$urandom(), $urandom()});

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    idle_odds = 3;
    foreach (dir_rows[i])
      offer_word(dir_rows[i].f, dir_rows[i].key, dir_rows[i].pay, dir_rows[i].typed,
                 dir_rows[i].want);

    phase_left = 0;
    mode = 0;
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (phase_left == 0) begin
        mode = $urandom_range(0, 2);
        phase_left = $urandom_range(40, 80);
        idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
      end
      phase_left--;
      if (n >= RAND_WORDS - CALM_TAIL) idle_odds = 0;
      if (n == 300) begin
        // receiver holds off while words keep coming, so the input must stall
        rx_hold_req = 1'b1;
        idle_odds = 0;
        phase_left = 30;
      end
      if (n == 600) begin
        // sender goes quiet until everything outstanding has come back
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge clk);
      end

      pick = $urandom_range(0, 99);
      case (mode)
        0: f = pick < 65 ? FUNC_ENQ : pick < 75 ? FUNC_DEQ : pick < 85 ? FUNC_REM : FUNC_POS;
        1: f = pick < 15 ? FUNC_ENQ : pick < 50 ? FUNC_DEQ : pick < 80 ? FUNC_REM : FUNC_POS;
        default: f = pick < 30 ? FUNC_ENQ : pick < 55 ? FUNC_DEQ : pick < 75 ? FUNC_REM : FUNC_POS;
      endcase

      // lookups mostly hit a held key, enqueues draw on a small pool to provoke duplicates
      if (f != FUNC_ENQ && held.size() != 0 && $urandom_range(0, 9) < 7)
        k = held[$urandom_range(0, held.size() - 1)].key;
      else if ($urandom_range(0, 4) == 0)
        k = KEY_W'({$urandom(), $urandom()});
      else
        k = key_pool[$urandom_range(0, POOL_N - 1)];

      p = {$urandom(), $urandom()};
      pick = $urandom_range(0, 19);
      if (pick == 0) p = '0;
      else if (pick == 1) p = '1;

      offer_word(f, k, p, 1'b0, '0);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("run covered %0d words: %0d enqueue, %0d dequeue, %0d remove, %0d position query",
             func_sent[0] + func_sent[1] + func_sent[2] + func_sent[3],
             func_sent[FUNC_ENQ], func_sent[FUNC_DEQ], func_sent[FUNC_REM], func_sent[FUNC_POS]);
    $display("replies ok %0d, duplicate %0d, empty %0d, not found %0d, full %0d; deepest queue %0d",
             status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_EMPTY],
             status_seen[ST_NOTFOUND], status_seen[ST_FULL], peak_depth);
    if (errors == 0) begin
      $display("PASS keyed_fifo_with_removal_unit");
    end else begin
      $display("FAIL keyed_fifo_with_removal_unit");
    end
    $finish;
  end

endmodule

// ===== keyed_fifo_with_removal_unit.f =====
rtl/kfr_pkg.sv
rtl/kfr_cell.sv
rtl/keyed_fifo_with_removal_unit.sv
rtl/kfr_checker.sv
tb/tb_top.sv
